/* hw/rtl/u8u16_pkg.sv */
// Shared types, constants and helpers for the UTF-8 to UTF-16 decoder.
// Used by the front decoder, the descriptor queue, the unit expander and the top level.
package u8u16_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [15:0] REPL_UNIT   = 16'hFFFD;
  localparam logic [20:0] MAX_POINT   = 21'h10FFFF;
  localparam logic [20:0] SURR_FIRST  = 21'h00D800;
  localparam logic [20:0] SURR_LAST   = 21'h00DFFF;
  localparam logic [20:0] SUPP_BASE   = 21'h010000;
  localparam logic [20:0] MIN_TWO     = 21'h000080;
  localparam logic [20:0] MIN_THREE   = 21'h000800;
  localparam logic [5:0]  HIGH_PREFIX = 6'b110110;  // 0xD800 >> 10
  localparam logic [5:0]  LOW_PREFIX  = 6'b110111;  // 0xDC00 >> 10

  typedef enum logic [2:0] {
    CLS_ASCII,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_INVALID
  } byte_class_t;

  // One decoded step: replacements first, then up to two tail units.
  typedef struct packed {
    logic [2:0]  repl_cnt;
    logic [1:0]  tail_cnt;
    logic [15:0] unit_a;
    logic [15:0] unit_b;
    logic        fin;
    logic        clean;
  } desc_t;

  function automatic byte_class_t classify(input logic [7:0] b);
    byte_class_t c;
    if (b inside {[8'h00:8'h7F]}) begin
      c = CLS_ASCII;
    end else if (b inside {[8'hC0:8'hDF]}) begin
      c = CLS_LEAD2;
    end else if (b inside {[8'hE0:8'hEF]}) begin
      c = CLS_LEAD3;
    end else if (b inside {[8'hF0:8'hF7]}) begin
      c = CLS_LEAD4;
    end else begin
      c = CLS_INVALID;
    end
    return c;
  endfunction

endpackage

/* hw/rtl/u8u16_front.sv */
// Front decoder: tracks the pending sequence and turns each byte into a descriptor.
// Depends on u8u16_pkg for the byte classes, constants and desc_t.
module u8u16_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          text_byte,
  input  logic                final_byte,
  input  logic                accept,
  output logic                has_units,
  output u8u16_pkg::desc_t    desc
);

  logic [1:0]  pend_r, pend_nxt;
  logic [1:0]  need_r, need_nxt;
  logic [20:0] part_r, part_nxt;
  logic        clean_r, clean_nxt;

  u8u16_pkg::byte_class_t cls;
  logic [20:0] cp;
  logic [20:0] supp;
  logic [20:0] lowest;
  logic [2:0]  taken;
  logic [2:0]  repl;
  logic [1:0]  tail;
  logic [15:0] unit_a;
  logic [15:0] unit_b;
  logic        fresh;
  logic        bad;
  logic        step_clean;

  always_comb begin
    cls    = u8u16_pkg::classify(text_byte);
    cp     = {part_r[14:0], text_byte[5:0]};
    supp   = cp - u8u16_pkg::SUPP_BASE;
    taken  = {1'b0, pend_r} + 3'd1;
    case (need_r)
      2'd1:    lowest = u8u16_pkg::MIN_TWO;
      2'd2:    lowest = u8u16_pkg::MIN_THREE;
      default: lowest = u8u16_pkg::SUPP_BASE;
    endcase
    bad = (cp < lowest) || (cp > u8u16_pkg::MAX_POINT) ||
          ((cp >= u8u16_pkg::SURR_FIRST) && (cp <= u8u16_pkg::SURR_LAST));

    fresh    = 1'b1;
    repl     = '0;
    tail     = '0;
    unit_a   = '0;
    unit_b   = '0;
    pend_nxt = pend_r;
    need_nxt = need_r;
    part_nxt = part_r;

    if (pend_r != 2'd0) begin
      if (text_byte[7:6] == 2'b10) begin
        fresh = 1'b0;
        if (pend_r >= need_r) begin
          if (bad) begin
            repl = taken;
          end else if (cp < u8u16_pkg::SUPP_BASE) begin
            tail   = 2'd1;
            unit_a = cp[15:0];
          end else begin
            tail   = 2'd2;
            unit_a = {u8u16_pkg::HIGH_PREFIX, supp[19:10]};
            unit_b = {u8u16_pkg::LOW_PREFIX, supp[9:0]};
          end
          pend_nxt = '0;
          need_nxt = '0;
          part_nxt = '0;
        end else if (final_byte) begin
          repl     = taken;
          pend_nxt = '0;
          need_nxt = '0;
          part_nxt = '0;
        end else begin
          pend_nxt = taken[1:0];
          part_nxt = cp;
        end
      end else begin
        // broken sequence: replace every pending byte, then decode this one
        repl     = {1'b0, pend_r};
        pend_nxt = '0;
        need_nxt = '0;
        part_nxt = '0;
      end
    end

    if (fresh) begin
      case (cls)
        u8u16_pkg::CLS_ASCII: begin
          tail   = 2'd1;
          unit_a = {8'h00, text_byte};
        end
        u8u16_pkg::CLS_LEAD2, u8u16_pkg::CLS_LEAD3, u8u16_pkg::CLS_LEAD4: begin
          if (final_byte) begin
            repl = repl + 3'd1;
          end else begin
            pend_nxt = 2'd1;
            case (cls)
              u8u16_pkg::CLS_LEAD2: begin
                need_nxt = 2'd1;
                part_nxt = {16'h0000, text_byte[4:0]};
              end
              u8u16_pkg::CLS_LEAD3: begin
                need_nxt = 2'd2;
                part_nxt = {17'h00000, text_byte[3:0]};
              end
              default: begin
                need_nxt = 2'd3;
                part_nxt = {18'h00000, text_byte[2:0]};
              end
            endcase
          end
        end
        default: begin
          repl = repl + 3'd1;
        end
      endcase
    end

    step_clean = clean_r & (repl == 3'd0);
    if (final_byte) begin
      pend_nxt  = '0;
      need_nxt  = '0;
      part_nxt  = '0;
      clean_nxt = 1'b1;
    end else begin
      clean_nxt = step_clean;
    end

    desc.repl_cnt = repl;
    desc.tail_cnt = tail;
    desc.unit_a   = unit_a;
    desc.unit_b   = unit_b;
    desc.fin      = final_byte;
    desc.clean    = step_clean;
    has_units     = (repl != 3'd0) || (tail != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= '0;
      need_r  <= '0;
      part_r  <= '0;
      clean_r <= 1'b1;
    end else if (accept) begin
      pend_r  <= pend_nxt;
      need_r  <= need_nxt;
      part_r  <= part_nxt;
      clean_r <= clean_nxt;
    end
  end

endmodule

/* hw/rtl/u8u16_fifo.sv */
// Short descriptor queue between the front decoder and the unit expander.
// Depends on u8u16_pkg for desc_t; depth comes from the top level.
module u8u16_fifo #(
  parameter int unsigned DEPTH = u8u16_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  u8u16_pkg::desc_t  wr_data,
  output logic              full,
  input  logic              rd_en,
  output u8u16_pkg::desc_t  rd_data,
  output logic              empty
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  u8u16_pkg::desc_t mem [DEPTH];

  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_wr;
  logic          do_rd;

  always_comb begin
    full    = (cnt_r == CW'(DEPTH));
    empty   = (cnt_r == '0);
    do_wr   = wr_en && !full;
    do_rd   = rd_en && !empty;
    rd_data = mem[rd_ptr_r];

    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

/* hw/rtl/u8u16_back.sv */
// Unit expander: unless out_stall holds, walks one descriptor a unit per cycle
// into the output register; needs u8u16_pkg for desc_t and the replacement unit.
module u8u16_back (
  input  logic              clk,
  input  logic              rst_n,
  input  u8u16_pkg::desc_t  desc,
  input  logic              desc_valid,
  output logic              desc_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [15:0]       out_code_unit,
  output logic              out_last_unit,
  output logic              out_text_clean
);

  logic [1:0]  idx_r, idx_nxt;
  logic        valid_r, valid_nxt;
  logic [15:0] unit_r, unit_nxt;
  logic        last_r, last_nxt;
  logic        clean_r, clean_nxt;

  logic [2:0]  total;
  logic [2:0]  pos;
  logic        load;
  logic        at_end;

  always_comb begin
    total  = desc.repl_cnt + {1'b0, desc.tail_cnt};
    pos    = {1'b0, idx_r};
    load   = desc_valid && (!valid_r || !out_stall);
    at_end = (pos == total - 3'd1);

    if (pos < desc.repl_cnt) begin
      unit_nxt = u8u16_pkg::REPL_UNIT;
    end else if (pos == desc.repl_cnt) begin
      unit_nxt = desc.unit_a;
    end else begin
      unit_nxt = desc.unit_b;
    end
    last_nxt  = desc.fin && at_end;
    clean_nxt = desc.fin && at_end && desc.clean;

    desc_pop  = load && at_end;
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (load) begin
      idx_nxt   = at_end ? '0 : idx_r + 2'd1;
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      unit_r  <= unit_nxt;
      last_r  <= last_nxt;
      clean_r <= clean_nxt;
    end
  end

  assign out_valid      = valid_r;
  assign out_code_unit  = unit_r;
  assign out_last_unit  = last_r;
  assign out_text_clean = clean_r;

endmodule

/* hw/rtl/utf8_to_utf16_decoder.sv */
// Top level of the UTF-8 to UTF-16 stream decoder.
// Depends on u8u16_pkg, u8u16_front, u8u16_fifo and u8u16_back.
//
//   channel | direction | transaction                         | handshake
//   --------+-----------+-------------------------------------+--------------------
//   in_     | input     | one text byte plus end-of-text flag | in_valid / in_stall
//   out_    | output    | one UTF-16 unit, last flag, clean   | out_valid / out_stall
//
// Cycles: a byte is taken in every cycle while the descriptor queue has room
//   (in_stall is simply "queue full"); the byte is decoded in that same cycle.
// Each byte yields zero to four units; the expander hands out one unit per cycle
//   while out_stall is low, so the output port sets the long-run rate; a byte's
//   first unit passes through the descriptor queue and then the output register.
// Reset (rst_n low, synchronous) empties the queue, drops any pending sequence and
//   marks the text clean; no clearing pass is needed.
// A stall on out_ holds the output register; the queue absorbs bursts from
//   multi-unit bytes before it back-pressures in_.
module utf8_to_utf16_decoder #(
  parameter int unsigned QUEUE_DEPTH = u8u16_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_text_byte,
  input  logic        in_final_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_code_unit,
  output logic        out_last_unit,
  output logic        out_text_clean
);

  u8u16_pkg::desc_t front_desc;
  u8u16_pkg::desc_t head_desc;
  logic             front_has_units;
  logic             in_accept;
  logic             q_full;
  logic             q_empty;
  logic             q_pop;

  // Take a transaction whenever the queue can hold its descriptor.
  assign in_stall  = q_full;
  assign in_accept = in_valid && !q_full;

  u8u16_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .text_byte  (in_text_byte),
    .final_byte (in_final_byte),
    .accept     (in_accept),
    .has_units  (front_has_units),
    .desc       (front_desc)
  );

  // Drop descriptors that carry no units (a lead or middle byte being gathered).
  u8u16_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_accept && front_has_units),
    .wr_data (front_desc),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (head_desc),
    .empty   (q_empty)
  );

  u8u16_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .desc           (head_desc),
    .desc_valid     (!q_empty),
    .desc_pop       (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_code_unit  (out_code_unit),
    .out_last_unit  (out_last_unit),
    .out_text_clean (out_text_clean)
  );

endmodule
